/* design/fvpe_pkg.sv */
// Shared types and constants for the four-variable polynomial evaluator.
package fvpe_pkg;

   localparam int COEF_W  = 48;
   localparam int COORD_W = 32;
   localparam int CSR_AW  = 5;
   localparam int CSR_DW  = 32;
   localparam int CFG_W   = 3;

   localparam logic [63:0] ONE_Q24     = 64'h0000_0000_0100_0000;
   localparam logic [127:0] ROUND_HALF = 128'h0080_0000;
   localparam logic [63:0] MONO_LIMIT  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TERM_LIMIT  = 64'h0020_0000_0000_0000;
   localparam logic signed [63:0] OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] OUT_MIN = -64'sh0000_8000_0000_0000;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_EVAL  = 1'b1;

   localparam logic [2:0] REG_TOTAL_ORDER    = 3'd0;
   localparam logic [2:0] REG_MAX_EXP_FIRST  = 3'd1;
   localparam logic [2:0] REG_MAX_EXP_SECOND = 3'd2;
   localparam logic [2:0] REG_MAX_EXP_THIRD  = 3'd3;
   localparam logic [2:0] REG_MAX_EXP_FOURTH = 3'd4;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POW_ISSUE,
      ST_POW_WAIT,
      ST_TERM_READ,
      ST_TERM_CHECK,
      ST_MONO_ISSUE,
      ST_MONO_WAIT,
      ST_COEF_ISSUE,
      ST_COEF_WAIT,
      ST_TERM_NEXT,
      ST_FINISH
   } fvpe_state_type;

   typedef enum logic [1:0] {
      MUL_IDLE,
      MUL_PP,
      MUL_RND,
      MUL_CLIP
   } mul_state_type;

   typedef struct packed {
      logic start;
      logic term;
   } mul_req_type;

   typedef struct packed {
      logic done;
      logic clip;
   } mul_rsp_type;

endpackage

/* design/four_var_poly_eval.sv */
// Top level: four-variable polynomial evaluator with coefficient table and APB registers.
//
// A write item (req_action = 0) stores req_coef_value in slot req_coef_index and
// returns nothing. An evaluate item (req_action = 1) returns one transfer on
// rsp_strobe, which is high for a single cycle and cannot be held off.
// Evaluation is sequential around one shared multiplier; each product runs four
// partial products of 32x32, then round, clip and handoff. First the four power
// tables are built, 4*MAX_ORDER products. Then the terms are walked in table
// order: a term that is masked off, lies beyond the table or has a zero
// coefficient passes only table read, check and advance; a live term adds four
// products into monomial and coefficient. At order five the walk covers 126 terms.
// busy stays high throughout; start is taken only while busy is low.
// Registers sit at byte address 4*i; the user must write them only while the block
// is idle, which the block itself does not enforce.
module four_var_poly_eval import fvpe_pkg::*; #(
   parameter int MAX_ORDER   = 5,
   parameter int TABLE_DEPTH = 128
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic                      req_action,
   input  logic        [6:0]         req_coef_index,
   input  logic signed [COEF_W-1:0]  req_coef_value,
   input  logic signed [COORD_W-1:0] req_first_coord,
   input  logic signed [COORD_W-1:0] req_second_coord,
   input  logic signed [COORD_W-1:0] req_third_coord,
   input  logic signed [COORD_W-1:0] req_fourth_coord,
   output logic                      rsp_strobe,
   output logic signed [COEF_W-1:0]  rsp_poly_value,
   output logic                      rsp_saturated,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic        [CSR_AW-1:0]  paddr,
   input  logic        [CSR_DW-1:0]  pwdata,
   output logic        [CSR_DW-1:0]  prdata,
   output logic                      pready
);

   localparam int AW        = $clog2(TABLE_DEPTH);
   localparam int EW        = $clog2(MAX_ORDER + 1);
   localparam int XW        = (EW > 3) ? EW : 3;
   localparam int NUM_TERMS = (MAX_ORDER + 1) * (MAX_ORDER + 2) * (MAX_ORDER + 3)
                              * (MAX_ORDER + 4) / 24;
   localparam int SW        = $clog2(NUM_TERMS + 1);
   localparam int CW        = (SW > AW + 1) ? SW : AW + 1;
   localparam int IW        = (AW + 1 > 7) ? AW + 1 : 7;

   // configuration registers
   logic [CFG_W-1:0] total_order_ff, max_exp_first_ff, max_exp_second_ff;
   logic [CFG_W-1:0] max_exp_third_ff, max_exp_fourth_ff;

   // sequencer state
   fvpe_state_type state_ff, state_in;

   logic signed [COORD_W-1:0] coord_ff [4];
   logic [63:0] pow_ff [4][MAX_ORDER+1];
   logic        pcl_ff [4][MAX_ORDER+1];
   logic [63:0] run_ff;
   logic        rclip_ff;
   logic [1:0]  v_ff;
   logic [EW-1:0] k_ff;
   logic [EW-1:0] n_ff, d_ff, c_ff, b_ff;
   logic [SW-1:0] slot_ff;
   logic          term_ok_ff;
   logic [63:0]   m_ff;
   logic          mc_ff;
   logic [1:0]    mj_ff;
   logic signed [63:0] sum_ff;
   logic          flag_ff;
   logic          rsp_strobe_ff;
   logic signed [COEF_W-1:0] rsp_poly_value_ff;
   logic          rsp_saturated_ff;

   // combinational
   logic          accept, accept_eval;
   logic          cfg_wr;
   logic [IW-1:0] wr_idx;
   logic          ram_wr_en, ram_rd_en;
   logic [COEF_W-1:0] coef;
   logic [63:0]   coef_sext;
   logic [EW-1:0] a_exp, rem_b, rem_c, ord;
   logic [EW-1:0] exp_of [4];
   logic [1:0]    pvar;
   logic [63:0]   pow_rd;
   logic          term_ok_next, last_term, k_last, coef_live;
   mul_req_type   mul_req;
   mul_rsp_type   mul_rsp;
   logic [63:0]   mul_a, mul_b;
   logic signed [63:0] mul_q;

   // ---------------- configuration port ----------------
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         total_order_ff    <= CFG_W'(5);
         max_exp_first_ff  <= CFG_W'(5);
         max_exp_second_ff <= CFG_W'(5);
         max_exp_third_ff  <= CFG_W'(5);
         max_exp_fourth_ff <= CFG_W'(5);
      end else if (cfg_wr) begin
         case (paddr[4:2])
            REG_TOTAL_ORDER:    total_order_ff    <= pwdata[CFG_W-1:0];
            REG_MAX_EXP_FIRST:  max_exp_first_ff  <= pwdata[CFG_W-1:0];
            REG_MAX_EXP_SECOND: max_exp_second_ff <= pwdata[CFG_W-1:0];
            REG_MAX_EXP_THIRD:  max_exp_third_ff  <= pwdata[CFG_W-1:0];
            REG_MAX_EXP_FOURTH: max_exp_fourth_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[4:2])
         REG_TOTAL_ORDER:    prdata = CSR_DW'(total_order_ff);
         REG_MAX_EXP_FIRST:  prdata = CSR_DW'(max_exp_first_ff);
         REG_MAX_EXP_SECOND: prdata = CSR_DW'(max_exp_second_ff);
         REG_MAX_EXP_THIRD:  prdata = CSR_DW'(max_exp_third_ff);
         REG_MAX_EXP_FOURTH: prdata = CSR_DW'(max_exp_fourth_ff);
         default:            prdata = '0;
      endcase
   end

   // ---------------- input transfer ----------------
   assign busy        = (state_ff != ST_IDLE);
   assign accept      = start & ~busy;
   assign accept_eval = accept & (req_action == ACT_EVAL);

   // writes outside the table are dropped
   assign wr_idx    = IW'(req_coef_index);
   assign ram_wr_en = accept & (req_action == ACT_WRITE) & (wr_idx < IW'(TABLE_DEPTH));

   fvpe_coef_ram #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (AW'(wr_idx)),
      .wr_data (req_coef_value),
      .rd_en   (ram_rd_en),
      .rd_addr (AW'(slot_ff)),
      .rd_data (coef)
   );

   assign coef_sext = {{(64-COEF_W){coef[COEF_W-1]}}, coef};
   assign coef_live = term_ok_ff && (coef != '0);

   // ---------------- term walk ----------------
   // order is clamped to what the power tables hold
   assign ord = (XW'(total_order_ff) > XW'(MAX_ORDER)) ? EW'(MAX_ORDER)
                                                      : EW'(total_order_ff);
   assign rem_c = n_ff - d_ff;
   assign rem_b = rem_c - c_ff;
   assign a_exp = rem_b - b_ff;
   assign exp_of[0] = a_exp;
   assign exp_of[1] = b_ff;
   assign exp_of[2] = c_ff;
   assign exp_of[3] = d_ff;
   // the last term of a degree has the fourth exponent equal to the degree
   assign last_term = (n_ff == ord) && (d_ff == n_ff);
   assign k_last    = (k_ff == EW'(MAX_ORDER));

   assign term_ok_next = (CW'(slot_ff) < CW'(TABLE_DEPTH))
                         && (XW'(a_exp) <= XW'(max_exp_first_ff))
                         && (XW'(b_ff)  <= XW'(max_exp_second_ff))
                         && (XW'(c_ff)  <= XW'(max_exp_third_ff))
                         && (XW'(d_ff)  <= XW'(max_exp_fourth_ff));

   assign pow_rd = pow_ff[pvar][exp_of[pvar]];

   // ---------------- next state ----------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:       if (accept_eval) state_in = ST_POW_ISSUE;
         ST_POW_ISSUE:  state_in = ST_POW_WAIT;
         ST_POW_WAIT: begin
            if (mul_rsp.done) begin
               if (k_last && (v_ff == 2'd3)) state_in = ST_TERM_READ;
               else state_in = ST_POW_ISSUE;
            end
         end
         ST_TERM_READ:  state_in = ST_TERM_CHECK;
         ST_TERM_CHECK: state_in = coef_live ? ST_MONO_ISSUE : ST_TERM_NEXT;
         ST_MONO_ISSUE: state_in = ST_MONO_WAIT;
         ST_MONO_WAIT: begin
            if (mul_rsp.done) state_in = (mj_ff == 2'd3) ? ST_COEF_ISSUE : ST_MONO_ISSUE;
         end
         ST_COEF_ISSUE: state_in = ST_COEF_WAIT;
         ST_COEF_WAIT:  if (mul_rsp.done) state_in = ST_TERM_NEXT;
         ST_TERM_NEXT:  state_in = last_term ? ST_FINISH : ST_TERM_READ;
         ST_FINISH:     state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // ---------------- state outputs ----------------
   always_comb begin
      mul_req.start = 1'b0;
      mul_req.term  = 1'b0;
      mul_a         = m_ff;
      mul_b         = pow_rd;
      ram_rd_en     = 1'b0;
      pvar          = mj_ff;
      case (state_ff)
         ST_POW_ISSUE: begin
            mul_req.start = 1'b1;
            mul_a         = run_ff;
            mul_b         = {{(64-COORD_W){coord_ff[v_ff][COORD_W-1]}}, coord_ff[v_ff]};
         end
         ST_TERM_READ:  ram_rd_en = (CW'(slot_ff) < CW'(TABLE_DEPTH));
         ST_TERM_CHECK: pvar = 2'd0;
         ST_MONO_ISSUE: mul_req.start = 1'b1;
         ST_COEF_ISSUE: begin
            mul_req.start = 1'b1;
            mul_req.term  = 1'b1;
            mul_b         = coef_sext;
         end
         default: ;
      endcase
   end

   fvpe_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .mul_q   (mul_q),
      .mul_rsp (mul_rsp)
   );

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_strobe_ff <= (state_ff == ST_FINISH);
      end
   end

   // ---------------- datapath ----------------
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept_eval) begin
               coord_ff[0] <= req_first_coord;
               coord_ff[1] <= req_second_coord;
               coord_ff[2] <= req_third_coord;
               coord_ff[3] <= req_fourth_coord;
               for (int i = 0; i < 4; i++) begin
                  pow_ff[i][0] <= ONE_Q24;
                  pcl_ff[i][0] <= 1'b0;
               end
               run_ff   <= ONE_Q24;
               rclip_ff <= 1'b0;
               v_ff     <= 2'd0;
               k_ff     <= EW'(1);
            end
         end
         ST_POW_WAIT: begin
            if (mul_rsp.done) begin
               pow_ff[v_ff][k_ff] <= mul_q;
               pcl_ff[v_ff][k_ff] <= rclip_ff | mul_rsp.clip;
               if (k_last) begin
                  v_ff     <= v_ff + 2'd1;
                  k_ff     <= EW'(1);
                  run_ff   <= ONE_Q24;
                  rclip_ff <= 1'b0;
                  n_ff     <= '0;
                  d_ff     <= '0;
                  c_ff     <= '0;
                  b_ff     <= '0;
                  slot_ff  <= '0;
                  sum_ff   <= '0;
                  flag_ff  <= 1'b0;
               end else begin
                  k_ff     <= k_ff + EW'(1);
                  run_ff   <= mul_q;
                  rclip_ff <= rclip_ff | mul_rsp.clip;
               end
            end
         end
         ST_TERM_READ: term_ok_ff <= term_ok_next;
         ST_TERM_CHECK: begin
            m_ff  <= pow_rd;
            mc_ff <= pcl_ff[0][a_exp] | pcl_ff[1][b_ff] | pcl_ff[2][c_ff] | pcl_ff[3][d_ff];
            mj_ff <= 2'd1;
         end
         ST_MONO_WAIT: begin
            if (mul_rsp.done) begin
               m_ff  <= mul_q;
               mc_ff <= mc_ff | mul_rsp.clip;
               mj_ff <= mj_ff + 2'd1;
            end
         end
         ST_COEF_WAIT: begin
            if (mul_rsp.done) begin
               sum_ff  <= sum_ff + mul_q;
               flag_ff <= flag_ff | mc_ff | mul_rsp.clip;
            end
         end
         ST_TERM_NEXT: begin
            slot_ff <= slot_ff + SW'(1);
            if (b_ff < rem_b) begin
               b_ff <= b_ff + EW'(1);
            end else if (c_ff < rem_c) begin
               c_ff <= c_ff + EW'(1);
               b_ff <= '0;
            end else if (d_ff < n_ff) begin
               d_ff <= d_ff + EW'(1);
               c_ff <= '0;
               b_ff <= '0;
            end else begin
               n_ff <= n_ff + EW'(1);
               d_ff <= '0;
               c_ff <= '0;
               b_ff <= '0;
            end
         end
         ST_FINISH: begin
            // clip the sum to 48 bits
            if (sum_ff > OUT_MAX) begin
               rsp_poly_value_ff <= COEF_W'(OUT_MAX);
               rsp_saturated_ff  <= 1'b1;
            end else if (sum_ff < OUT_MIN) begin
               rsp_poly_value_ff <= COEF_W'(OUT_MIN);
               rsp_saturated_ff  <= 1'b1;
            end else begin
               rsp_poly_value_ff <= sum_ff[COEF_W-1:0];
               rsp_saturated_ff  <= flag_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_poly_value = rsp_poly_value_ff;
   assign rsp_saturated  = rsp_saturated_ff;

   // ---------------- assertions ----------------
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for more than one cycle");

   a_eval_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_action == ACT_EVAL)) |=> busy)
      else $error("evaluate transfer did not raise busy");

   a_mul_done_wait: assert property (@(posedge clock) disable iff (reset)
      mul_rsp.done |-> ((state_ff == ST_POW_WAIT) || (state_ff == ST_MONO_WAIT)
                        || (state_ff == ST_COEF_WAIT)))
      else $error("product returned outside a wait state");

   a_slot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TERM_NEXT) |-> (int'(slot_ff) < NUM_TERMS))
      else $error("term slot ran past the term count");

endmodule

/* design/fvpe_mul.sv */
// Multi-cycle signed Q.24 multiplier with rounding and clipping.
module fvpe_mul import fvpe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  mul_req_type        mul_req,
   input  logic        [63:0] op_a,
   input  logic        [63:0] op_b,
   output logic signed [63:0] mul_q,
   output mul_rsp_type        mul_rsp
);

   mul_state_type state_ff, state_in;
   logic [1:0]   cnt_ff;
   logic [63:0]  x_ff, y_ff;
   logic         neg_ff, term_ff;
   logic [127:0] acc_ff;
   logic [63:0]  q_ff;
   logic         clip_ff, done_ff;

   logic         ld_en, pp_en, rnd_en, clip_en;
   logic [63:0]  pp;
   logic [1:0]   pp_pos;
   logic [127:0] pp_wide;
   logic [63:0]  lim, qmag, qsel;
   logic         ovf;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         MUL_IDLE: if (mul_req.start) state_in = MUL_PP;
         MUL_PP:   if (cnt_ff == 2'd3) state_in = MUL_RND;
         MUL_RND:  state_in = MUL_CLIP;
         MUL_CLIP: state_in = MUL_IDLE;
         default:  state_in = MUL_IDLE;
      endcase
   end

   always_comb begin
      ld_en   = 1'b0;
      pp_en   = 1'b0;
      rnd_en  = 1'b0;
      clip_en = 1'b0;
      case (state_ff)
         MUL_IDLE: ld_en   = mul_req.start;
         MUL_PP:   pp_en   = 1'b1;
         MUL_RND:  rnd_en  = 1'b1;
         MUL_CLIP: clip_en = 1'b1;
         default:  ld_en   = 1'b0;
      endcase
   end

   // one 32x32 partial product per cycle
   assign pp      = x_ff[32*cnt_ff[0] +: 32] * y_ff[32*cnt_ff[1] +: 32];
   assign pp_pos  = {1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]};
   assign pp_wide = {64'd0, pp} << {pp_pos, 5'd0};

   assign lim  = term_ff ? TERM_LIMIT : MONO_LIMIT;
   assign qmag = acc_ff[87:24];
   assign ovf  = (|acc_ff[127:88]) || (qmag > lim);
   assign qsel = ovf ? lim : qmag;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= MUL_IDLE;
         cnt_ff   <= 2'd0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= clip_en;
         if (ld_en) cnt_ff <= 2'd0;
         else if (pp_en) cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (ld_en) begin
         x_ff    <= op_a[63] ? (64'd0 - op_a) : op_a;
         y_ff    <= op_b[63] ? (64'd0 - op_b) : op_b;
         neg_ff  <= op_a[63] ^ op_b[63];
         term_ff <= mul_req.term;
         acc_ff  <= 128'd0;
      end else if (pp_en) begin
         acc_ff <= acc_ff + pp_wide;
      end else if (rnd_en) begin
         acc_ff <= acc_ff + ROUND_HALF;
      end
      if (clip_en) begin
         q_ff    <= neg_ff ? (64'd0 - qsel) : qsel;
         clip_ff <= ovf;
      end
   end

   assign mul_q        = q_ff;
   assign mul_rsp.done = done_ff;
   assign mul_rsp.clip = clip_ff;

endmodule

/* design/fvpe_coef_ram.sv */
// Coefficient table: one write port, one registered read port.
module fvpe_coef_ram import fvpe_pkg::*; #(
   parameter int DEPTH = 128,
   parameter int AW    = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [COEF_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [COEF_W-1:0] rd_data
);

   logic [COEF_W-1:0] mem_ff [DEPTH];
   logic [COEF_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* test/fvpe_checker.sv */
// Checker for the polynomial evaluator: tracks registers and table, predicts, compares.
`timescale 1ns / 100ps
module fvpe_checker import fvpe_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  logic                      req_action,
   input  logic        [6:0]         req_coef_index,
   input  logic signed [COEF_W-1:0]  req_coef_value,
   input  logic signed [COORD_W-1:0] req_first_coord,
   input  logic signed [COORD_W-1:0] req_second_coord,
   input  logic signed [COORD_W-1:0] req_third_coord,
   input  logic signed [COORD_W-1:0] req_fourth_coord,
   input  logic                      rsp_strobe,
   input  logic signed [COEF_W-1:0]  rsp_poly_value,
   input  logic                      rsp_saturated,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic        [CSR_AW-1:0]  paddr,
   input  logic        [CSR_DW-1:0]  pwdata,
   input  logic                      pready,
   output int                        fail_count,
   output int                        pending_count
);
   localparam int ORDER_CAP = 5;
   localparam int SLOTS     = 128;

   typedef struct {
      logic [COEF_W-1:0] value;
      logic              sat;
   } poly_result_type;

   logic [CFG_W-1:0]  order_reg, exp_a_reg, exp_b_reg, exp_c_reg, exp_d_reg;
   logic [COEF_W-1:0] coef_tab [SLOTS];
   poly_result_type   expected_q [$];

   assign pending_count = expected_q.size();

   // {clip, value}: exact product, >> 24 rounded half away from zero, clipped to +-lim
   function automatic logic [64:0] fx_mul(input logic signed [63:0] a,
                                           input logic signed [63:0] b,
                                           input logic [63:0] lim);
      logic [63:0]  x, y, qv;
      logic [127:0] prod;
      logic         clip;
      x = a[63] ? (~a + 64'd1) : a;
      y = b[63] ? (~b + 64'd1) : b;
      prod = ({64'd0, x} * {64'd0, y} + 128'h80_0000) >> 24;
      clip = prod > {64'd0, lim};
      qv = clip ? lim : prod[63:0];
      if (a[63] != b[63]) qv = ~qv + 64'd1;
      return {clip, qv};
   endfunction

   function automatic poly_result_type eval_poly(input logic signed [31:0] u,
                                                 input logic signed [31:0] v,
                                                 input logic signed [31:0] w,
                                                 input logic signed [31:0] z);
      logic signed [63:0] pw_tab [4][ORDER_CAP+1];
      logic               pc_tab [4][ORDER_CAP+1];
      logic signed [63:0] crd [4];
      logic signed [63:0] sum, mono, coef;
      logic [64:0]        r;
      logic               flag, mc;
      int                 ord, slot, a;
      poly_result_type    res;
      crd[0] = u; crd[1] = v; crd[2] = w; crd[3] = z;
      for (int i = 0; i < 4; i++) begin
         pw_tab[i][0] = 64'sd1 <<< 24;
         pc_tab[i][0] = 1'b0;
         for (int k = 1; k <= ORDER_CAP; k++) begin
            r = fx_mul(pw_tab[i][k-1], crd[i], MONO_LIMIT);
            pw_tab[i][k] = r[63:0];
            pc_tab[i][k] = pc_tab[i][k-1] | r[64];
         end
      end
      ord = (order_reg > ORDER_CAP) ? ORDER_CAP : order_reg;
      sum = 0;
      flag = 1'b0;
      slot = 0;
      for (int n = 0; n <= ord; n++)
         for (int d = 0; d <= n; d++)
            for (int c = 0; c <= n - d; c++)
               for (int b = 0; b <= n - d - c; b++) begin
                  a = n - d - c - b;
                  if (slot < SLOTS && a <= exp_a_reg && b <= exp_b_reg &&
                      c <= exp_c_reg && d <= exp_d_reg) begin
                     coef = {{16{coef_tab[slot][47]}}, coef_tab[slot]};
                     if (coef != 0) begin
                        mc = pc_tab[0][a] | pc_tab[1][b] | pc_tab[2][c] | pc_tab[3][d];
                        r = fx_mul(pw_tab[0][a], pw_tab[1][b], MONO_LIMIT);
                        mc |= r[64];
                        r = fx_mul(r[63:0], pw_tab[2][c], MONO_LIMIT);
                        mc |= r[64];
                        r = fx_mul(r[63:0], pw_tab[3][d], MONO_LIMIT);
                        mono = r[63:0];
                        flag |= mc | r[64];
                        r = fx_mul(mono, coef, TERM_LIMIT);
                        flag |= r[64];
                        sum += $signed(r[63:0]);
                     end
                  end
                  slot++;
               end
      if (sum > OUT_MAX) begin
         sum = OUT_MAX;
         flag = 1'b1;
      end else if (sum < OUT_MIN) begin
         sum = OUT_MIN;
         flag = 1'b1;
      end
      res.value = sum[47:0];
      res.sat = flag;
      return res;
   endfunction

   always @(posedge clock) begin
      poly_result_type want;
      if (reset) begin
         order_reg  <= 3'd5;
         exp_a_reg  <= 3'd5;
         exp_b_reg  <= 3'd5;
         exp_c_reg  <= 3'd5;
         exp_d_reg  <= 3'd5;
         fail_count <= 0;
         expected_q.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (paddr[4:2])
               REG_TOTAL_ORDER:    order_reg <= pwdata[2:0];
               REG_MAX_EXP_FIRST:  exp_a_reg <= pwdata[2:0];
               REG_MAX_EXP_SECOND: exp_b_reg <= pwdata[2:0];
               REG_MAX_EXP_THIRD:  exp_c_reg <= pwdata[2:0];
               REG_MAX_EXP_FOURTH: exp_d_reg <= pwdata[2:0];
               default: ;
            endcase
         end
         if (start && !busy) begin
            if (req_action == ACT_WRITE)
               coef_tab[req_coef_index] <= req_coef_value;
            else
               expected_q.push_back(eval_poly(req_first_coord, req_second_coord,
                                              req_third_coord, req_fourth_coord));
         end
         if (rsp_strobe) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result value=%h sat=%b", $time,
                        rsp_poly_value, rsp_saturated);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (rsp_poly_value !== want.value || rsp_saturated !== want.sat) begin
                  $display("%0t: mismatch value exp=%h act=%h sat exp=%b act=%b", $time,
                           want.value, rsp_poly_value, want.sat, rsp_saturated);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

/* test/testbench.sv */
// Testbench top: drives items and register writes into the evaluator, reports the verdict.
`timescale 1ns / 100ps
module testbench;
   import fvpe_pkg::*;

   localparam int PHASES       = 18;
   localparam int PHASE_ITEMS  = 100;
   localparam int STALL_LIMIT  = 20000;  // covers the worst evaluate plus a long gap
   localparam int SETTLE_CYCLES = 16;

   logic                      clock, reset, start, busy;
   logic                      req_action;
   logic        [6:0]         req_coef_index;
   logic signed [COEF_W-1:0]  req_coef_value;
   logic signed [COORD_W-1:0] req_first_coord, req_second_coord;
   logic signed [COORD_W-1:0] req_third_coord, req_fourth_coord;
   logic                      rsp_strobe, rsp_saturated;
   logic signed [COEF_W-1:0]  rsp_poly_value;
   logic                      psel, penable, pwrite, pready;
   logic        [CSR_AW-1:0]  paddr;
   logic        [CSR_DW-1:0]  pwdata, prdata;
   int                        fail_count, pending_count;
   int                        quiet_cycles;
   logic                      gaps_on;

   four_var_poly_eval DUT (.*);
   fvpe_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Watchdog: any transfer (item, result or register write) resets the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Mostly short gaps, a few long ones; none while a stretch has gaps off.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (!gaps_on || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Sparse coefficients keep most terms cheap; extremes drive term clipping.
   function automatic logic [COEF_W-1:0] pick_coef();
      case ($urandom_range(0, 9))
         6:       return 48'($signed($urandom_range(0, 32'hFFFF_FFFF)) >>> 2);
         7:       return 48'({$urandom(), $urandom()});
         8:       return 48'h7FFF_FFFF_FFFF;
         9:       return 48'h8000_0000_0000;
         default: return '0;
      endcase
   endfunction

   function automatic logic [COORD_W-1:0] pick_coord();
      case ($urandom_range(0, 9))
         0:       return '0;
         5, 6:    return $urandom();
         7:       return 32'h7FFF_FFFF;
         8:       return 32'h8000_0000;
         9:       return $urandom_range(0, 1) ? 32'h0100_0000 : 32'hFF00_0000;
         default: return $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
      endcase
   endfunction

   // One transfer. With more set and a zero gap, start stays high for the next item.
   task automatic put_item(input logic act, input logic [6:0] idx,
                           input logic [COEF_W-1:0] coef,
                           input logic [COORD_W-1:0] c1, input logic [COORD_W-1:0] c2,
                           input logic [COORD_W-1:0] c3, input logic [COORD_W-1:0] c4,
                           input logic more);
      int gap;
      req_action       <= act;
      req_coef_index   <= idx;
      req_coef_value   <= coef;
      req_first_coord  <= c1;
      req_second_coord <= c2;
      req_third_coord  <= c3;
      req_fourth_coord <= c4;
      if (!start) start <= 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      gap = pick_gap();
      if (!more && gap == 0) gap = 1;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic put_write(input logic [6:0] idx, input logic [COEF_W-1:0] coef,
                            input logic more);
      put_item(ACT_WRITE, idx, coef, $urandom(), $urandom(), $urandom(), $urandom(), more);
   endtask

   task automatic put_eval(input logic [COORD_W-1:0] c1, input logic [COORD_W-1:0] c2,
                           input logic [COORD_W-1:0] c3, input logic [COORD_W-1:0] c4,
                           input logic more);
      put_item(ACT_EVAL, 7'($urandom()), 48'({$urandom(), $urandom()}), c1, c2, c3, c4,
               more);
   endtask

   // Sender pauses until every expected result is back, then lets the block settle.
   task automatic drain();
      @(posedge clock);
      while (pending_count != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] reg_idx, input logic [CFG_W-1:0] val);
      psel    <= 1'b1;
      pwrite  <= 1'b1;
      penable <= 1'b0;
      paddr   <= {reg_idx, 2'b00};
      pwdata  <= {29'($urandom_range(0, 32'h1FFF_FFFF)), val};  // upper bits ignored
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [CFG_W-1:0] ord, input logic [CFG_W-1:0] ea,
                             input logic [CFG_W-1:0] eb, input logic [CFG_W-1:0] ec,
                             input logic [CFG_W-1:0] ed);
      csr_write(REG_TOTAL_ORDER, ord);
      csr_write(REG_MAX_EXP_FIRST, ea);
      csr_write(REG_MAX_EXP_SECOND, eb);
      csr_write(REG_MAX_EXP_THIRD, ec);
      csr_write(REG_MAX_EXP_FOURTH, ed);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      gaps_on = 1'b1;
      req_action = ACT_WRITE;
      req_coef_index = '0;
      req_coef_value = '0;
      req_first_coord = '0;
      req_second_coord = '0;
      req_third_coord = '0;
      req_fourth_coord = '0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill the whole table first so no evaluate reads an unwritten slot.
      // Slot 0 and 1 get the coefficient extremes, the rest random picks, mostly zero.
      gaps_on = 1'b0;
      put_write(7'd0, 48'h7FFF_FFFF_FFFF, 1'b1);
      put_write(7'd1, 48'h8000_0000_0000, 1'b1);
      for (int i = 2; i < 128; i++)
         put_write(7'(i), pick_coef(), i != 127);
      gaps_on = 1'b1;

      // Directed evaluates at reset configuration: coordinate extremes and unity.
      put_eval('0, '0, '0, '0, 1'b0);
      put_eval(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0);
      put_eval(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
      put_eval(32'h0100_0000, 32'hFF00_0000, 32'h0080_0000, 32'h0000_0001, 1'b0);
      put_eval(32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      // Neutralize the extreme slots, then an evaluate with every coordinate at unity.
      put_write(7'd0, 48'h0000_0100_0000, 1'b1);
      put_write(7'd1, 48'hFFFF_FF00_0000, 1'b0);
      put_eval(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 1'b0);
      drain();

      // Phases: zero order with all limits zero, everything out of range high
      // (order above the cap), mixed masks, then random settings.
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0:       set_config(3'd0, 3'd0, 3'd0, 3'd0, 3'd0);
            1:       set_config(3'd7, 3'd7, 3'd7, 3'd7, 3'd7);
            2:       set_config(3'd5, 3'd0, 3'd5, 3'd0, 3'd5);
            3:       set_config(3'd6, 3'd5, 3'd0, 3'd5, 3'd0);
            default: set_config(3'($urandom()), 3'($urandom()), 3'($urandom()),
                                3'($urandom()), 3'($urandom()));
         endcase
         gaps_on = $urandom_range(0, 3) != 0;
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if ($urandom_range(0, 99) < 35)
               put_eval(pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                        k != PHASE_ITEMS - 1);
            else
               put_write(7'($urandom()), pick_coef(), k != PHASE_ITEMS - 1);
         end
         drain();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule
